// File: sv/running_median_two_heaps_assert.svh
// assertion macros shared by the checker
`ifndef RUNNING_MEDIAN_TWO_HEAPS_ASSERT_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_ASSERT_SVH
// antecedent implies consequent in the same cycle
`define RMH_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("rmh check failed");
// antecedent implies consequent in the next cycle
`define RMH_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("rmh check failed");
`endif

// File: sv/rmh_pkg.sv
// ----------------------------------------------------------------------------
// rmh_pkg
// shared types for the running median block
// ----------------------------------------------------------------------------
package rmh_pkg;
  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_START = 10'b0000000010,
    ST_UPRD  = 10'b0000000100,
    ST_UPCMP = 10'b0000001000,
    ST_DNRD  = 10'b0000010000,
    ST_DNCMP = 10'b0000100000,
    ST_SWAP  = 10'b0001000000,
    ST_BAL   = 10'b0010000000,
    ST_TOPS  = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } rmh_state_e;
endpackage

// File: sv/rmh_ram.sv
// ----------------------------------------------------------------------------
// rmh_ram
// generic single write, single read port ram with registered read
// ----------------------------------------------------------------------------
module rmh_ram #(
  parameter int Width = 16,
  parameter int Depth = 513
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: sv/running_median_two_heaps.sv
// ----------------------------------------------------------------------------
// running_median_two_heaps
// running median of an unsigned sample stream kept in two heaps
// ----------------------------------------------------------------------------
// One request on the slave side yields one response on the master side:
// the floored median of all held samples, the count held and an overflow
// flag when the store is already full. The lower half lives in a max-heap,
// the upper half in a min-heap, each in its own ram with a registered read.
// A small sequencer walks the heaps one level at a time: an insert reads
// and compares the parent per level climbed, a top removal reads the left
// child, then the right child, and compares per level sunk, plus setup
// and readout of both tops. An accepted request may need an insert, a top
// removal and a reinsert into the other heap before its response is
// valid; a refused sample goes straight to readout. The sequencer
// returns to idle before the next request is taken, and tready is high
// only while the sequencer is idle. A finished response waits in the
// output register, so the next request can be taken and worked on
// meanwhile; the sequencer only holds at readout if the previous response
// is still not taken. Only occupied heap entries are ever used, so no
// clearing pass is needed after reset.
module running_median_two_heaps
  import rmh_pkg::*;
#(
  parameter int CAPACITY    = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // [15:0] median, [26:16] sample_count, [27] overflow
);
  localparam int Depth = CAPACITY / 2 + 1;
  localparam int AW    = $clog2(Depth);
  localparam int SW    = $clog2(Depth + 1);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int B     = SAMPLE_BITS;

  rmh_state_e state_q, state_d;

  // heap sizes
  logic [SW-1:0] lsize_q, lsize_d, usize_q, usize_d;
  // current op: heap select (1 = lower/max), index, moving value
  logic          sel_q, sel_d;
  logic [AW-1:0] idx_q, idx_d, best_q, best_d;
  logic [B-1:0]  val_q, val_d, cur_q, cur_d, bval_q, bval_d;
  logic [SW-1:0] n_q, n_d;
  logic          phase_q, phase_d;   // sift-down: 0 = left child, 1 = right child
  logic          bal_q, bal_d;       // balance step done, so an insert ends in readout
  logic          ovf_q, ovf_d;
  logic [B-1:0]  ltop_q, ltop_d;
  logic [15:0]   med_q, med_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovfo_q, ovfo_d;     // overflow flag of the held response

  // response register
  logic          ovalid_q, ovalid_d;
  logic          oslot;              // response register free by the next edge
  assign oslot = !ovalid_q || m_axis_tready;

  // ram ports, one shared access path muxed by heap select
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [B-1:0]  wdata, lrd, urd, rd;
  logic          lwe, uwe;
  assign lwe = we & sel_q;
  assign uwe = we & ~sel_q;
  assign rd  = sel_q ? lrd : urd;

  rmh_ram #(.Width(B), .Depth(Depth)) u_lram (
    .clk_i, .we_i(lwe), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(lrd));
  rmh_ram #(.Width(B), .Depth(Depth)) u_uram (
    .clk_i, .we_i(uwe), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(urd));

  // comparator function: a above b for the selected heap
  function automatic logic above(input logic s, input logic [B-1:0] a, input logic [B-1:0] b);
    above = s ? (a > b) : (a < b);
  endfunction

  logic [SW:0]   total;
  logic [AW-1:0] parent, lchild;
  logic [SW:0]   lc_w, rc_w;
  logic [B:0]    msum;
  assign total  = {1'b0, lsize_q} + {1'b0, usize_q};
  assign parent = (idx_q - AW'(1)) >> 1;
  assign lc_w   = (SW+1)'({idx_q, 1'b1});
  assign rc_w   = lc_w + (SW+1)'(1);
  assign lchild = lc_w[AW-1:0];
  assign msum   = {1'b0, ltop_q} + {1'b0, rd};

  logic [B-1:0] smp;
  assign smp = B'(s_axis_tdata);

  always_comb begin
    state_d = state_q;
    lsize_d = lsize_q; usize_d = usize_q;
    sel_d = sel_q; idx_d = idx_q; best_d = best_q;
    val_d = val_q; cur_d = cur_q; bval_d = bval_q; n_d = n_q;
    phase_d = phase_q; bal_d = bal_q; ovf_d = ovf_q;
    ltop_d = ltop_q; med_d = med_q; cnt_d = cnt_q; ovfo_d = ovfo_q;
    we = 1'b0; waddr = idx_q; wdata = val_q; raddr = '0;
    unique case (state_q)
      ST_IDLE: begin
        raddr = '0;
        if (s_axis_tvalid && s_axis_tready) begin
          val_d = smp;
          bal_d = 1'b0;
          if (total >= (SW+1)'(CAPACITY)) begin
            ovf_d = 1'b1;
            state_d = ST_TOPS;
          end else begin
            ovf_d = 1'b0;
            state_d = ST_START;
            sel_d = 1'b1;   // read lower top
          end
        end
      end
      ST_START: begin
        // rd holds lower top (valid only if lsize > 0)
        if (total == '0 || (lsize_q != '0 && val_q < lrd)) begin
          sel_d = 1'b1;
          idx_d = lsize_q[AW-1:0];
          lsize_d = lsize_q + SW'(1);
        end else begin
          sel_d = 1'b0;
          idx_d = usize_q[AW-1:0];
          usize_d = usize_q + SW'(1);
        end
        state_d = ST_UPRD;
      end
      ST_UPRD: begin
        // value sits logically at idx; fetch parent
        if (idx_q == '0) begin
          we = 1'b1;
          state_d = bal_q ? ST_TOPS : ST_BAL;
        end else begin
          raddr = parent;
          state_d = ST_UPCMP;
        end
      end
      ST_UPCMP: begin
        if (above(sel_q, val_q, rd)) begin
          we = 1'b1; wdata = rd;   // parent moves down
          idx_d = parent;
          state_d = ST_UPRD;
        end else begin
          we = 1'b1;
          state_d = bal_q ? ST_TOPS : ST_BAL;
        end
      end
      ST_BAL: begin
        bal_d = 1'b1;
        if (lsize_q > usize_q + SW'(1)) begin
          sel_d = 1'b1;
          n_d = lsize_q - SW'(1);
          lsize_d = lsize_q - SW'(1);
          raddr = '0;
          state_d = ST_SWAP;
        end else if (usize_q > lsize_q + SW'(1)) begin
          sel_d = 1'b0;
          n_d = usize_q - SW'(1);
          usize_d = usize_q - SW'(1);
          raddr = '0;
          state_d = ST_SWAP;
        end else begin
          state_d = ST_TOPS;
        end
      end
      ST_SWAP: begin
        // rd = old top; fetch last element
        bval_d = rd;
        raddr = n_q[AW-1:0];
        idx_d = '0;
        phase_d = 1'b0;
        state_d = ST_DNRD;
      end
      ST_DNRD: begin
        // first visit: rd is the last element, which starts at the root
        if (idx_q == '0) begin
          cur_d = rd;
        end
        best_d = '1;
        if (lc_w < {1'b0, n_q}) begin
          raddr = lchild;
          state_d = ST_DNCMP;
          phase_d = 1'b0;
        end else begin
          we = 1'b1; wdata = cur_d;
          // carry moved top into the other heap
          val_d = bval_q;
          sel_d = ~sel_q;
          if (sel_q) begin
            idx_d = usize_q[AW-1:0];
            usize_d = usize_q + SW'(1);
          end else begin
            idx_d = lsize_q[AW-1:0];
            lsize_d = lsize_q + SW'(1);
          end
          state_d = ST_UPRD;
        end
      end
      ST_DNCMP: begin
        if (!phase_q) begin
          // rd = left child
          if (above(sel_q, rd, cur_q)) begin
            best_d = lchild; val_d = rd;
          end else begin
            best_d = idx_q; val_d = cur_q;
          end
          if (rc_w < {1'b0, n_q}) begin
            raddr = rc_w[AW-1:0];
            phase_d = 1'b1;
          end else begin
            phase_d = 1'b1;
            raddr = rc_w[AW-1:0];
            best_d = (above(sel_q, rd, cur_q)) ? lchild : idx_q;
          end
        end else begin
          logic [AW-1:0] b;
          logic [B-1:0]  bv;
          b = best_q; bv = val_q;
          if (rc_w < {1'b0, n_q} && above(sel_q, rd, bv)) begin
            b = rc_w[AW-1:0]; bv = rd;
          end
          if (b == idx_q) begin
            we = 1'b1; waddr = idx_q; wdata = cur_q;
            val_d = bval_q;
            sel_d = ~sel_q;
            phase_d = 1'b0;
            if (sel_q) begin
              idx_d = usize_q[AW-1:0];
              usize_d = usize_q + SW'(1);
            end else begin
              idx_d = lsize_q[AW-1:0];
              lsize_d = lsize_q + SW'(1);
            end
            state_d = ST_UPRD;
          end else begin
            we = 1'b1; waddr = idx_q; wdata = bv;   // child moves up
            idx_d = b;
            best_d = '0;
            phase_d = 1'b0;
            state_d = ST_DNRD;
          end
        end
      end
      ST_TOPS: begin
        // read lower top, then upper top
        if (!phase_q) begin
          sel_d = 1'b1; raddr = '0; phase_d = 1'b1;
        end else begin
          ltop_d = lrd; sel_d = 1'b0; raddr = '0; phase_d = 1'b0;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // hold here while the previous response still waits
        if (oslot) begin
          cnt_d = total[CW-1:0];
          ovfo_d = ovf_q;
          if (total == '0) begin
            med_d = '0;
          end else if (!total[0]) begin
            med_d = 16'(msum >> 1);
          end else if (lsize_q > usize_q) begin
            med_d = 16'(ltop_q);
          end else begin
            med_d = 16'(urd);
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (m_axis_tvalid && m_axis_tready) ovalid_d = 1'b0;
    if (state_q == ST_OUT && oslot) ovalid_d = 1'b1;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {4'b0, ovfo_q, 11'(cnt_q), med_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      lsize_q  <= '0;
      usize_q  <= '0;
      ovalid_q <= 1'b0;
      phase_q  <= 1'b0;
      bal_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      lsize_q  <= lsize_d;
      usize_q  <= usize_d;
      ovalid_q <= ovalid_d;
      phase_q  <= phase_d;
      bal_q    <= bal_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q <= sel_d; idx_q <= idx_d; best_q <= best_d;
    val_q <= val_d; cur_q <= cur_d; bval_q <= bval_d; n_q <= n_d;
    ovf_q <= ovf_d; ltop_q <= ltop_d; med_q <= med_d; cnt_q <= cnt_d;
    ovfo_q <= ovfo_d;
  end
endmodule

// File: sv/rmh_checker.sv
// ----------------------------------------------------------------------------
// rmh_checker
// port level checks for the running median block
// ----------------------------------------------------------------------------
`include "running_median_two_heaps_assert.svh"
module rmh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);
  // a held response keeps its data
  `RMH_ASSERT_NXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  // a held response stays valid until taken
  `RMH_ASSERT_NXT(a_keep, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  // accepted request drops ready next cycle
  `RMH_ASSERT_NXT(a_one, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // an overflow flag comes with a nonzero count
  `RMH_ASSERT_IMP(a_ovf, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[27],
                  m_axis_tdata[26:16] != 11'd0)
endmodule

bind running_median_two_heaps rmh_checker u_rmh_checker (.*);
